### hdl/hpt_pkg.sv
// Shared types and codes for the homogeneous point transform.
package hpt_pkg;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_POINT3D = 3'd1;
  localparam logic [2:0] OP_VECTOR  = 3'd2;
  localparam logic [2:0] OP_POINT2D = 3'd3;
  localparam logic [2:0] OP_INT2D   = 3'd4;

  // quotient bits produced by the divider, rounding bit included
  localparam int QBITS = 34;

  typedef struct packed {
    logic       valid;
    logic [2:0] op;
    logic       dodiv;
    logic       negx;
    logic       negy;
    logic       negz;
  } ctl_t;

endpackage

### hdl/hpt_dot.sv
// Coefficient store and four row dot products with Q rounding, five stages.
module hpt_dot
  import hpt_pkg::*;
#(
  parameter int FB = 16,
  parameter int DW = 66 - FB
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0]           in_op,
  input  logic [1:0]           in_row,
  input  logic [1:0]           in_col,
  input  logic signed [31:0]   in_coef,
  input  logic signed [31:0]   in_x,
  input  logic signed [31:0]   in_y,
  input  logic signed [31:0]   in_z,
  output ctl_t                 ctl,
  output logic signed [DW-1:0] dx,
  output logic signed [DW-1:0] dy,
  output logic signed [DW-1:0] dz,
  output logic signed [DW-1:0] dw
);

  localparam logic signed [31:0] ONE  = 32'(64'sd1 <<< FB);
  localparam logic signed [65:0] HALF = 66'(64'sd1 <<< (FB - 1));

  logic              s1_valid;
  logic [2:0]        s1_op;
  logic [1:0]        s1_row;
  logic [1:0]        s1_col;
  logic signed [31:0] s1_coef;
  logic signed [31:0] s1_x;
  logic signed [31:0] s1_y;
  logic signed [31:0] s1_z;

  logic signed [31:0] mat [4][4];
  logic signed [31:0] vec [4];

  logic              s2_valid;
  logic [2:0]        s2_op;
  logic signed [63:0] prod [4][4];

  logic              s3_valid;
  logic [2:0]        s3_op;
  logic signed [64:0] pair [4][2];

  logic              s4_valid;
  logic [2:0]        s4_op;
  logic signed [65:0] sum [4];

  logic signed [65:0] rsum [4];
  logic signed [DW-1:0] rnd [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op   <= in_op;
      s1_row  <= in_row;
      s1_col  <= in_col;
      s1_coef <= in_coef;
      s1_x    <= in_x;
      s1_y    <= in_y;
      s1_z    <= in_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mat[r][c] <= (r == c) ? ONE : 32'sd0;
        end
      end
    end else if (en && s1_valid && s1_op == OP_LOAD) begin
      mat[s1_row][s1_col] <= s1_coef;
    end
  end

  always_comb begin
    vec[0] = s1_x;
    vec[1] = s1_y;
    vec[2] = (s1_op == OP_POINT3D || s1_op == OP_VECTOR) ? s1_z : 32'sd0;
    vec[3] = (s1_op == OP_VECTOR) ? 32'sd0 : ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      ctl      <= '0;
    end else if (en) begin
      s2_valid  <= s1_valid && s1_op >= OP_POINT3D && s1_op <= OP_INT2D;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      ctl.valid <= s4_valid;
      ctl.op    <= s4_op;
      ctl.dodiv <= 1'b0;
      ctl.negx  <= 1'b0;
      ctl.negy  <= 1'b0;
      ctl.negz  <= 1'b0;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      rsum[r] = sum[r] + (sum[r][65] ? HALF - 66'sd1 : HALF);
      rnd[r]  = DW'(rsum[r] >>> FB);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op <= s1_op;
      s3_op <= s2_op;
      s4_op <= s3_op;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod[r][c] <= 64'(mat[r][c]) * 64'(vec[c]);
        end
        pair[r][0] <= 65'(prod[r][0]) + 65'(prod[r][1]);
        pair[r][1] <= 65'(prod[r][2]) + 65'(prod[r][3]);
        sum[r]     <= 66'(pair[r][0]) + 66'(pair[r][1]);
      end
      dx <= rnd[0];
      dy <= rnd[1];
      dz <= (s4_op == OP_POINT2D || s4_op == OP_INT2D) ? '0 : rnd[2];
      dw <= rnd[3];
    end
  end

endmodule

### hdl/hpt_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module hpt_div
  import hpt_pkg::*;
#(
  parameter int FB = 16,
  parameter int MW = 50
) (
  input  logic             clk,
  input  logic             en,
  input  logic [MW-1:0]    un,
  input  logic [MW-1:0]    ud,
  output logic [QBITS-1:0] q,
  output logic             ovf
);

  logic [MW-1:0]    rem  [QBITS+1];
  logic [QBITS-1:0] nlo  [QBITS+1];
  logic [QBITS-1:0] quo  [QBITS+1];
  logic [MW-1:0]    dsr  [QBITS+1];
  logic             ovfs [QBITS+1];

  logic [MW+QBITS-1:0] ext;

  assign ext = {QBITS'(0), un} << (FB + 1);

  always_ff @(posedge clk) begin
    if (en) begin
      ovfs[0] <= {QBITS'(0), un} >= ({QBITS'(0), ud} << (QBITS - 1 - FB));
      rem[0]  <= un >> (QBITS - 1 - FB);
      nlo[0]  <= ext[QBITS-1:0];
      quo[0]  <= '0;
      dsr[0]  <= ud;
    end
  end

  for (genvar i = 1; i <= QBITS; i++) begin : g_st
    logic [MW:0] rr;
    logic        ge;
    assign rr = {rem[i-1], nlo[i-1][QBITS-1]};
    assign ge = rr >= {1'b0, dsr[i-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? MW'(rr - {1'b0, dsr[i-1]}) : MW'(rr);
        nlo[i]  <= nlo[i-1] << 1;
        quo[i]  <= {quo[i-1][QBITS-2:0], ge};
        dsr[i]  <= dsr[i-1];
        ovfs[i] <= ovfs[i-1];
      end
    end
  end

  assign q   = quo[QBITS];
  assign ovf = ovfs[QBITS];

endmodule

### hdl/hpt_out.sv
// Final rounding, clamping and the two-entry output buffer.
module hpt_out
  import hpt_pkg::*;
#(
  parameter int FB = 16,
  parameter int DW = 66 - FB
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  input  logic signed [DW-1:0] dx,
  input  logic signed [DW-1:0] dy,
  input  logic signed [DW-1:0] dz,
  input  logic [QBITS-1:0]     qx,
  input  logic [QBITS-1:0]     qy,
  input  logic [QBITS-1:0]     qz,
  input  logic                 ovfx,
  input  logic                 ovfy,
  input  logic                 ovfz,
  output logic                 space,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [95:0]          m_tdata,   // out_x, out_y, out_z
  output logic                 m_tuser    // saturated
);

  localparam logic signed [DW:0] HALF  = (DW+1)'(64'sd1 <<< (FB - 1));
  localparam logic signed [DW:0] MAXV  = (DW+1)'(64'sd2147483647);
  localparam logic signed [DW:0] MAXI  = (DW+1)'(64'sd2147483648 - (64'sd1 <<< FB));
  localparam logic signed [DW:0] MINV  = (DW+1)'(-64'sd2147483648);

  function automatic logic [32:0] finish(input logic signed [DW-1:0] d,
                                         input logic [QBITS-1:0] qv,
                                         input logic ov, input logic neg,
                                         input logic dodiv, input logic intm);
    logic [QBITS-1:0]   r;
    logic signed [DW:0] rv;
    logic signed [DW:0] t;
    logic signed [DW:0] v;
    logic signed [DW:0] mx;
    r  = QBITS'(({1'b0, qv} + (QBITS+1)'(1)) >> 1);
    rv = $signed((DW+1)'({1'b0, r}));
    t  = (DW+1)'(d) + ((d < 0) ? HALF - 1 : HALF);
    mx = intm ? MAXI : MAXV;
    if (dodiv) begin
      v = neg ? -rv : rv;
    end else if (intm) begin
      v = (t >>> FB) <<< FB;
    end else begin
      v = (DW+1)'(d);
    end
    if (dodiv && ov) begin
      finish = neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7fff_ffff};
    end else if (v > mx) begin
      finish = {1'b1, mx[31:0]};
    end else if (v < MINV) begin
      finish = {1'b1, 32'h8000_0000};
    end else begin
      finish = {1'b0, v[31:0]};
    end
  endfunction

  logic [32:0] fx, fy, fz;
  logic [96:0] entry [2];
  logic [1:0]  cnt;
  logic        wp, rp;
  logic        push, pop;
  logic        intm;

  assign intm = ctl.op == OP_INT2D;
  assign fx   = finish(dx, qx, ovfx, ctl.negx, ctl.dodiv, intm);
  assign fy   = finish(dy, qy, ovfy, ctl.negy, ctl.dodiv, intm);
  assign fz   = finish(dz, qz, ovfz, ctl.negz, ctl.dodiv, 1'b0);

  assign space    = cnt != 2'd2;
  assign push     = space && ctl.valid;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = cnt != 2'd0;
  assign m_tdata  = entry[rp][95:0];
  assign m_tuser  = entry[rp][96];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= {fx[32] | fy[32] | fz[32], fz[31:0], fy[31:0], fx[31:0]};
    end
  end

endmodule

### hdl/homogeneous_point_transform.sv
// Top level of the homogeneous point transform.
//
// Input channel s_*: s_tuser is the operation (load, point3d, vector,
// point2d, integer point2d); s_tdata carries row, column, coefficient and
// x, y, z. A load writes one matrix coefficient and gives no result; codes
// above integer point2d are dropped. Every transform gives one result on
// m_*: x, y, z in m_tdata and the saturation flag in m_tuser.
// An accepted item passes through, in order: the input register, the
// products, the pair sums, the row sums, the rounded dot outputs, the
// magnitudes, the pipelined divider (one quotient bit per stage) and
// the output buffer, which drives m_tvalid.
// One transfer per cycle while s_tready is high; all stages advance together.
// A load affects every item accepted after it.
// Reset empties the pipeline and the buffer and sets the matrix to identity.
// When the receiver stalls, the two-entry output buffer fills and then
// s_tready drops until a slot frees; nothing is lost or repeated.
module homogeneous_point_transform
  import hpt_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // row_index, column_index, coefficient, in_x, in_y, in_z
  input  logic [2:0]   s_tuser,   // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // out_x, out_y, out_z
  output logic         m_tuser    // saturated
);

  localparam int FB = FRACTION_BITS;
  localparam int DW = 66 - FB;
  localparam logic signed [DW-1:0] ONE = DW'(64'sd1 <<< FB);

  logic en;

  ctl_t                 dctl;
  logic signed [DW-1:0] dx, dy, dz, dw;

  ctl_t                 s6_ctl;
  logic signed [DW-1:0] s6_x, s6_y, s6_z;
  logic [DW-1:0]        ux, uy, uz, uw;

  ctl_t                 lctl [QBITS+1];
  logic signed [DW-1:0] lx   [QBITS+1];
  logic signed [DW-1:0] ly   [QBITS+1];
  logic signed [DW-1:0] lz   [QBITS+1];

  logic [QBITS-1:0] qx, qy, qz;
  logic             ovfx, ovfy, ovfz;

  assign s_tready = en;

  hpt_dot #(.FB(FB), .DW(DW)) u_dot (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_row   (s_tdata[1:0]),
    .in_col   (s_tdata[3:2]),
    .in_coef  (s_tdata[35:4]),
    .in_x     (s_tdata[67:36]),
    .in_y     (s_tdata[99:68]),
    .in_z     (s_tdata[131:100]),
    .ctl      (dctl),
    .dx       (dx),
    .dy       (dy),
    .dz       (dz),
    .dw       (dw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_ctl <= '0;
    end else if (en) begin
      s6_ctl.valid <= dctl.valid;
      s6_ctl.op    <= dctl.op;
      s6_ctl.dodiv <= dctl.op == OP_POINT3D && dw != '0 && dw != ONE;
      s6_ctl.negx  <= dx[DW-1] ^ dw[DW-1];
      s6_ctl.negy  <= dy[DW-1] ^ dw[DW-1];
      s6_ctl.negz  <= dz[DW-1] ^ dw[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_x <= dx;
      s6_y <= dy;
      s6_z <= dz;
      ux   <= dx[DW-1] ? DW'(-dx) : DW'(dx);
      uy   <= dy[DW-1] ? DW'(-dy) : DW'(dy);
      uz   <= dz[DW-1] ? DW'(-dz) : DW'(dz);
      uw   <= dw[DW-1] ? DW'(-dw) : DW'(dw);
    end
  end

  hpt_div #(.FB(FB), .MW(DW)) u_divx (
    .clk(clk), .en(en), .un(ux), .ud(uw), .q(qx), .ovf(ovfx)
  );
  hpt_div #(.FB(FB), .MW(DW)) u_divy (
    .clk(clk), .en(en), .un(uy), .ud(uw), .q(qy), .ovf(ovfy)
  );
  hpt_div #(.FB(FB), .MW(DW)) u_divz (
    .clk(clk), .en(en), .un(uz), .ud(uw), .q(qz), .ovf(ovfz)
  );

  // side line matching the divider depth
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QBITS; i++) begin
        lctl[i] <= '0;
      end
    end else if (en) begin
      lctl[0] <= s6_ctl;
      for (int i = 1; i <= QBITS; i++) begin
        lctl[i] <= lctl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lx[0] <= s6_x;
      ly[0] <= s6_y;
      lz[0] <= s6_z;
      for (int i = 1; i <= QBITS; i++) begin
        lx[i] <= lx[i-1];
        ly[i] <= ly[i-1];
        lz[i] <= lz[i-1];
      end
    end
  end

  hpt_out #(.FB(FB), .DW(DW)) u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lctl[QBITS]),
    .dx       (lx[QBITS]),
    .dy       (ly[QBITS]),
    .dz       (lz[QBITS]),
    .qx       (qx),
    .qy       (qy),
    .qz       (qz),
    .ovfx     (ovfx),
    .ovfy     (ovfy),
    .ovfz     (ovfz),
    .space    (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  a_dot_op: assert property (@(posedge clk) disable iff (rst)
    dctl.valid |-> (dctl.op == OP_POINT3D || dctl.op == OP_VECTOR ||
                    dctl.op == OP_POINT2D || dctl.op == OP_INT2D))
    else $error("load or unused code reached the transform path");
  a_div_op: assert property (@(posedge clk) disable iff (rst)
    s6_ctl.dodiv |-> s6_ctl.op == OP_POINT3D)
    else $error("divide flagged outside point3d");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");
  a_hold_line: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(lctl[QBITS]))
    else $error("pipeline moved while stalled");
`endif

endmodule
